>>> sv/grw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Grid ray wall intersect package
// Shared widths, register codes, reset values, datapath operation codes and
// the command and status bundles between the controller and the datapath.
// ============================================================================
package grw_pkg;

   localparam int MAP_SIDE_DEF = 24;

   localparam int POS_W      = 19;
   localparam int TRIG_W     = 16;
   localparam int DIST_W     = 24;
   localparam int HDIST_W    = 23;
   localparam int IDX_OUT_W  = 16;
   localparam int TILE_W     = 8;
   localparam int RC_IN_W    = 5;
   localparam int SHIFT_W    = 4;
   localparam int MAXD_W     = 16;
   localparam int STEPS_W    = 6;

   // Internal arithmetic widths: positions and distances, divider operand,
   // and tile indices.
   localparam int W          = 48;
   localparam int NUM_W      = 40;
   localparam int IDX_W      = 40;

   localparam int SAT24      = 8388607;
   localparam int SAT16      = 32767;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SHIFT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEPS    = 2'd2;

   localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST  = 4'd6;
   localparam logic [MAXD_W-1:0]  MAX_DISTANCE_RST = 16'd1536;
   localparam logic [STEPS_W-1:0] MAX_STEPS_RST    = 6'd25;

   localparam logic [3:0] OP_NONE     = 4'd0;
   localparam logic [3:0] OP_CLEAR    = 4'd1;
   localparam logic [3:0] OP_TILE_WR  = 4'd2;
   localparam logic [3:0] OP_LOAD     = 4'd3;
   localparam logic [3:0] OP_INIT     = 4'd4;
   localparam logic [3:0] OP_SAT      = 4'd5;
   localparam logic [3:0] OP_CAP_HYP  = 4'd6;
   localparam logic [3:0] OP_CAP_STEP = 4'd7;
   localparam logic [3:0] OP_MUL_LO   = 4'd8;
   localparam logic [3:0] OP_MUL_HI   = 4'd9;
   localparam logic [3:0] OP_INDEX    = 4'd10;
   localparam logic [3:0] OP_PROBE    = 4'd11;
   localparam logic [3:0] OP_ADVANCE  = 4'd12;
   localparam logic [3:0] OP_SAVE     = 4'd13;
   localparam logic [3:0] OP_EMIT     = 4'd14;

   typedef struct packed {
      logic [3:0] op;
      logic       walk_h;    // 0: vertical-line walk, 1: horizontal-line walk
      logic       mul_step;  // 0: multiply the first distance, 1: the step
   } grw_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic den_zero;
      logic div_done;
      logic walk_stop;
   } grw_status_type;

endpackage
`default_nettype wire

>>> sv/grid_ray_wall_intersect.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Grid ray wall intersect
// Tile map plus two grid walks per cast request; reports both wall distances
// and the tile and point of the nearer hit.
// ============================================================================
// After reset the block is busy while it clears the MAP_SIDE*MAP_SIDE tile map
// (576 entries by default). A tile write request is taken in the idle state,
// leaves busy low and gives no result. A cast request runs two walks; each
// walk does its two divisions in the radix-4 divider and then reads the map
// memory read port once per probe, with 1 to max_steps + 1 probes per walk. A
// walk whose trig value is zero does no divisions and no probes. The result
// is on the rsp_ ports for the single cycle that rsp_valid is high, the first
// cycle with busy low again; the receiver cannot hold it off.
module grid_ray_wall_intersect #(
   parameter int MAP_SIDE = grw_pkg::MAP_SIDE_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_cmd,
   input  logic [grw_pkg::RC_IN_W-1:0]          req_tile_row,
   input  logic [grw_pkg::RC_IN_W-1:0]          req_tile_col,
   input  logic [grw_pkg::TILE_W-1:0]           req_tile_value,
   input  logic [grw_pkg::POS_W-1:0]            req_player_x,
   input  logic [grw_pkg::POS_W-1:0]            req_player_y,
   input  logic signed [grw_pkg::TRIG_W-1:0]    req_sine_of_angle,
   input  logic signed [grw_pkg::TRIG_W-1:0]    req_cosine_of_angle,
   output logic                                 rsp_valid,
   output logic signed [grw_pkg::DIST_W-1:0]    rsp_vertical_distance,
   output logic [grw_pkg::HDIST_W-1:0]          rsp_horizontal_distance,
   output logic signed [grw_pkg::IDX_OUT_W-1:0] rsp_hit_col,
   output logic signed [grw_pkg::IDX_OUT_W-1:0] rsp_hit_row,
   output logic signed [grw_pkg::DIST_W-1:0]    rsp_hit_x,
   output logic signed [grw_pkg::DIST_W-1:0]    rsp_hit_y,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [grw_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [grw_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import grw_pkg::*;

   logic [SHIFT_W-1:0] block_shift_ff, block_shift_in;
   logic [MAXD_W-1:0]  max_distance_ff, max_distance_in;
   logic [STEPS_W-1:0] max_steps_ff, max_steps_in;

   grw_cmd_type    cmd;
   grw_status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      block_shift_in  = block_shift_ff;
      max_distance_in = max_distance_ff;
      max_steps_in    = max_steps_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BLOCK_SHIFT:  block_shift_in  = csr_wdata[SHIFT_W-1:0];
            CSR_MAX_DISTANCE: max_distance_in = csr_wdata[MAXD_W-1:0];
            CSR_MAX_STEPS:    max_steps_in    = csr_wdata[STEPS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_shift_ff  <= BLOCK_SHIFT_RST;
         max_distance_ff <= MAX_DISTANCE_RST;
         max_steps_ff    <= MAX_STEPS_RST;
      end else begin
         block_shift_ff  <= block_shift_in;
         max_distance_ff <= max_distance_in;
         max_steps_ff    <= max_steps_in;
      end
   end

   grw_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .busy    (busy),
      .cmd     (cmd),
      .status  (status)
   );

   grw_dpath #(
      .MAP_SIDE (MAP_SIDE)
   ) u_dpath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .block_shift             (block_shift_ff),
      .max_distance            (max_distance_ff),
      .max_steps               (max_steps_ff),
      .req_tile_row            (req_tile_row),
      .req_tile_col            (req_tile_col),
      .req_tile_value          (req_tile_value),
      .req_player_x            (req_player_x),
      .req_player_y            (req_player_y),
      .req_sine_of_angle       (req_sine_of_angle),
      .req_cosine_of_angle     (req_cosine_of_angle),
      .rsp_valid               (rsp_valid),
      .rsp_vertical_distance   (rsp_vertical_distance),
      .rsp_horizontal_distance (rsp_horizontal_distance),
      .rsp_hit_col             (rsp_hit_col),
      .rsp_hit_row             (rsp_hit_row),
      .rsp_hit_x               (rsp_hit_x),
      .rsp_hit_y               (rsp_hit_y)
   );

   // A result only appears once the controller has returned to idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_cast_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd) |=> (busy && !rsp_valid))
      else $error("cast request did not start a walk");

   a_tile_write: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_cmd) |=> (!busy && !rsp_valid))
      else $error("tile write request was not a single cycle");

endmodule
`default_nettype wire

>>> sv/grw_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Signed divider
// Radix-4 restoring divider, two quotient bits per cycle, quotient truncated
// toward zero. The result and a one-cycle done pulse are registered at the end
// of the last iteration after start.
// ============================================================================
module grw_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [grw_pkg::NUM_W-1:0]  num,
   input  logic signed [grw_pkg::TRIG_W-1:0] den,
   output logic                              done,
   output logic signed [grw_pkg::NUM_W-1:0]  quot
);
   import grw_pkg::*;

   localparam int ITERS = NUM_W / 2;
   localparam int CNT_W = $clog2(ITERS);

   logic                     run_ff, run_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [TRIG_W-1:0]        rem_ff, rem_in;
   logic [TRIG_W-1:0]        d_ff, d_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [NUM_W-1:0]         quo_ff, quo_in;
   logic                     neg_ff, neg_in;
   logic signed [NUM_W-1:0]  quot_ff, quot_in;

   logic [TRIG_W:0]          t1, t2, r1, r2;
   logic                     ge1, ge2;
   logic [NUM_W-1:0]         quo_next;

   always_comb begin
      t1       = {rem_ff, num_ff[NUM_W-1]};
      ge1      = t1 >= {1'b0, d_ff};
      r1       = ge1 ? t1 - {1'b0, d_ff} : t1;
      t2       = {r1[TRIG_W-1:0], num_ff[NUM_W-2]};
      ge2      = t2 >= {1'b0, d_ff};
      r2       = ge2 ? t2 - {1'b0, d_ff} : t2;
      quo_next = {quo_ff[NUM_W-3:0], ge1, ge2};
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = '0;
         num_in = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         d_in   = den[TRIG_W-1] ? TRIG_W'(-den) : TRIG_W'(den);
         neg_in = num[NUM_W-1] ^ den[TRIG_W-1];
      end else if (run_ff) begin
         num_in = num_ff << 2;
         rem_in = r2[TRIG_W-1:0];
         quo_in = quo_next;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ITERS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            quot_in = neg_ff ? -$signed(quo_next) : $signed(quo_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      d_ff    <= d_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

>>> sv/grw_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Grid ray wall intersect datapath
// Tile map memory, walk registers, shared divider and split multiplier,
// probe logic and the result registers. Driven one operation per cycle.
// ============================================================================
module grw_dpath #(
   parameter int MAP_SIDE = grw_pkg::MAP_SIDE_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  grw_pkg::grw_cmd_type                 cmd,
   output grw_pkg::grw_status_type              status,
   input  logic [grw_pkg::SHIFT_W-1:0]          block_shift,
   input  logic [grw_pkg::MAXD_W-1:0]           max_distance,
   input  logic [grw_pkg::STEPS_W-1:0]          max_steps,
   input  logic [grw_pkg::RC_IN_W-1:0]          req_tile_row,
   input  logic [grw_pkg::RC_IN_W-1:0]          req_tile_col,
   input  logic [grw_pkg::TILE_W-1:0]           req_tile_value,
   input  logic [grw_pkg::POS_W-1:0]            req_player_x,
   input  logic [grw_pkg::POS_W-1:0]            req_player_y,
   input  logic signed [grw_pkg::TRIG_W-1:0]    req_sine_of_angle,
   input  logic signed [grw_pkg::TRIG_W-1:0]    req_cosine_of_angle,
   output logic                                 rsp_valid,
   output logic signed [grw_pkg::DIST_W-1:0]    rsp_vertical_distance,
   output logic [grw_pkg::HDIST_W-1:0]          rsp_horizontal_distance,
   output logic signed [grw_pkg::IDX_OUT_W-1:0] rsp_hit_col,
   output logic signed [grw_pkg::IDX_OUT_W-1:0] rsp_hit_row,
   output logic signed [grw_pkg::DIST_W-1:0]    rsp_hit_x,
   output logic signed [grw_pkg::DIST_W-1:0]    rsp_hit_y
);
   import grw_pkg::*;

   localparam int DEPTH  = MAP_SIDE * MAP_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int RC_W   = $clog2(MAP_SIDE);

   localparam logic signed [W-1:0]     HI24 = W'(SAT24);
   localparam logic signed [W-1:0]     LO24 = ~HI24;
   localparam logic signed [IDX_W-1:0] HI16 = IDX_W'(SAT16);
   localparam logic signed [IDX_W-1:0] LO16 = ~HI16;

   function automatic logic signed [DIST_W-1:0] sat24(input logic signed [W-1:0] v);
      logic signed [DIST_W-1:0] r;
      if (v > HI24) r = HI24[DIST_W-1:0];
      else if (v < LO24) r = LO24[DIST_W-1:0];
      else r = v[DIST_W-1:0];
      return r;
   endfunction

   function automatic logic signed [IDX_OUT_W-1:0] sat16(input logic signed [IDX_W-1:0] v);
      logic signed [IDX_OUT_W-1:0] r;
      if (v > HI16) r = HI16[IDX_OUT_W-1:0];
      else if (v < LO16) r = LO16[IDX_OUT_W-1:0];
      else r = v[IDX_OUT_W-1:0];
      return r;
   endfunction

   logic [TILE_W-1:0] map_mem [DEPTH];

   logic [POS_W-1:0]          px_ff, py_ff;
   logic signed [TRIG_W-1:0]  sn_ff, cs_ff;
   logic signed [W-1:0]       a_ff, da_ff, hyp_ff, h2_ff, c_ff, dc_ff;
   logic signed [37:0]        plo_ff;
   logic signed [IDX_W-1:0]   along_ff, cross_ff;
   logic [TILE_W-1:0]         rd_data_ff;
   logic [STEPS_W-1:0]        steps_ff;
   logic [ADDR_W-1:0]         clear_addr_ff;

   logic signed [DIST_W-1:0]    v_dist_ff, v_x_ff, v_y_ff, h_x_ff, h_y_ff;
   logic [HDIST_W-1:0]          h_dist_ff;
   logic signed [IDX_OUT_W-1:0] v_col_ff, v_row_ff, h_col_ff, h_row_ff;

   logic                        rsp_valid_ff;
   logic signed [DIST_W-1:0]    rsp_vd_ff, rsp_x_ff, rsp_y_ff;
   logic [HDIST_W-1:0]          rsp_hd_ff;
   logic signed [IDX_OUT_W-1:0] rsp_col_ff, rsp_row_ff;

   // Walk geometry for the walk selected by the controller.
   logic [4:0]                bq;
   logic signed [W-1:0]       blk, pa_w, pc_w, a_init, da_init, t_hyp, t_step;
   logic signed [TRIG_W-1:0]  den, cf_src;
   logic signed [TRIG_W:0]    cf;
   logic                      fwd;
   logic signed [NUM_W-1:0]   div_num, div_quot;
   logic                      div_start, div_done;

   logic signed [W-1:0]       m_op;
   logic signed [20:0]        m_lo;
   logic signed [19:0]        m_hi;
   logic signed [37:0]        p_lo;
   logic signed [36:0]        p_hi;
   logic signed [59:0]        p_full, p_shift;
   logic signed [W-1:0]       mq;

   logic signed [W-1:0]       along_full, cross_full;
   logic signed [IDX_W-1:0]   row, col;
   logic                      probe_in;
   logic [ADDR_W-1:0]         probe_addr, tile_addr, wr_addr;
   logic                      tile_ok, mem_we;
   logic [TILE_W-1:0]         wr_data;

   logic signed [W-1:0]       mag, limit_w;
   logic [HDIST_W-1:0]        hd_sat;
   logic                      h_wins;

   always_comb begin
      bq      = 5'd8 + {1'b0, block_shift};
      blk     = W'(1) << bq;
      pa_w    = $signed(W'(cmd.walk_h ? py_ff : px_ff));
      pc_w    = $signed(W'(cmd.walk_h ? px_ff : py_ff));
      den     = cmd.walk_h ? sn_ff : cs_ff;
      fwd     = cmd.walk_h ? sn_ff[TRIG_W-1] : (!cs_ff[TRIG_W-1] && (cs_ff != '0));
      cf_src  = cmd.walk_h ? cs_ff : sn_ff;
      cf      = -$signed({cf_src[TRIG_W-1], cf_src});
      a_init  = (pa_w & ~(blk - W'(1))) + (fwd ? blk : '0);
      da_init = fwd ? blk : -blk;
      t_hyp   = (a_init - pa_w) <<< 14;
      t_step  = da_ff <<< 14;
   end

   assign div_start = (cmd.op == OP_INIT) || (cmd.op == OP_CAP_HYP);
   assign div_num   = (cmd.op == OP_INIT) ? t_hyp[NUM_W-1:0] : t_step[NUM_W-1:0];

   grw_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // The distance times the cross factor is split into two partial products,
   // low then high; the floor of the Q1.14 product is an arithmetic shift.
   always_comb begin
      m_op    = cmd.mul_step ? h2_ff : hyp_ff;
      m_lo    = $signed({1'b0, m_op[19:0]});
      m_hi    = m_op[39:20];
      p_lo    = m_lo * cf;
      p_hi    = m_hi * cf;
      p_full  = (60'(p_hi) <<< 20) + 60'(plo_ff);
      p_shift = p_full >>> 14;
      mq      = p_shift[W-1:0];
   end

   always_comb begin
      along_full = a_ff >>> bq;
      cross_full = c_ff >>> bq;
      row        = cmd.walk_h ? along_ff : cross_ff;
      col        = cmd.walk_h ? cross_ff : along_ff;
      probe_in   = !row[IDX_W-1] && (row < IDX_W'(MAP_SIDE)) &&
                   !col[IDX_W-1] && (col < IDX_W'(MAP_SIDE));
      probe_addr = ADDR_W'(int'(row[RC_W-1:0]) * MAP_SIDE + int'(col[RC_W-1:0]));
      tile_ok    = (int'(req_tile_row) < MAP_SIDE) && (int'(req_tile_col) < MAP_SIDE);
      tile_addr  = ADDR_W'(int'(req_tile_row) * MAP_SIDE + int'(req_tile_col));
      mem_we     = (cmd.op == OP_CLEAR) || ((cmd.op == OP_TILE_WR) && tile_ok);
      wr_addr    = (cmd.op == OP_CLEAR) ? clear_addr_ff : tile_addr;
      wr_data    = (cmd.op == OP_CLEAR) ? '0 : req_tile_value;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (cmd.op == OP_PROBE) begin
         rd_data_ff <= probe_in ? map_mem[probe_addr] : '0;
      end
   end

   always_comb begin
      mag     = (cmd.walk_h && hyp_ff[W-1]) ? -hyp_ff : hyp_ff;
      limit_w = $signed(W'({max_distance, 8'h00}));
      hd_sat  = (mag > HI24) ? HDIST_W'(SAT24) : mag[HDIST_W-1:0];
      h_wins  = $signed({1'b0, h_dist_ff}) < v_dist_ff;
   end

   assign status.clear_last = clear_addr_ff == ADDR_W'(DEPTH - 1);
   assign status.den_zero   = den == '0;
   assign status.div_done   = div_done;
   assign status.walk_stop  = (rd_data_ff != '0) || (steps_ff >= max_steps) ||
                              (mag >= limit_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.op == OP_CLEAR) clear_addr_ff <= clear_addr_ff + 1'b1;
         rsp_valid_ff <= cmd.op == OP_EMIT;
      end

      unique case (cmd.op)
         OP_LOAD: begin
            px_ff <= req_player_x;
            py_ff <= req_player_y;
            sn_ff <= req_sine_of_angle;
            cs_ff <= req_cosine_of_angle;
         end
         OP_INIT: begin
            a_ff  <= a_init;
            da_ff <= da_init;
         end
         OP_CAP_HYP: begin
            hyp_ff <= W'(div_quot);
         end
         OP_CAP_STEP: begin
            h2_ff    <= W'(div_quot);
            steps_ff <= '0;
         end
         OP_MUL_LO: begin
            plo_ff <= p_lo;
         end
         OP_MUL_HI: begin
            if (cmd.mul_step) dc_ff <= mq;
            else c_ff <= pc_w + mq;
         end
         OP_INDEX: begin
            along_ff <= along_full[IDX_W-1:0] - (fwd ? IDX_W'(0) : IDX_W'(1));
            cross_ff <= cross_full[IDX_W-1:0];
         end
         OP_ADVANCE: begin
            hyp_ff   <= hyp_ff + h2_ff;
            a_ff     <= a_ff + da_ff;
            c_ff     <= c_ff + dc_ff;
            steps_ff <= steps_ff + 1'b1;
         end
         OP_SAVE: begin
            if (cmd.walk_h) begin
               h_dist_ff <= hd_sat;
               h_x_ff    <= sat24(c_ff);
               h_y_ff    <= sat24(a_ff);
               h_col_ff  <= sat16(cross_ff);
               h_row_ff  <= sat16(along_ff);
            end else begin
               v_dist_ff <= sat24(hyp_ff);
               v_x_ff    <= sat24(a_ff);
               v_y_ff    <= sat24(c_ff);
               v_col_ff  <= sat16(along_ff);
               v_row_ff  <= sat16(cross_ff);
            end
         end
         OP_SAT: begin
            // A zero divisor means the ray never crosses this family of lines.
            if (cmd.walk_h) begin
               h_dist_ff <= HDIST_W'(SAT24);
               h_x_ff    <= '0;
               h_y_ff    <= '0;
               h_col_ff  <= '0;
               h_row_ff  <= '0;
            end else begin
               v_dist_ff <= DIST_W'(SAT24);
               v_x_ff    <= '0;
               v_y_ff    <= '0;
               v_col_ff  <= '0;
               v_row_ff  <= '0;
            end
         end
         OP_EMIT: begin
            rsp_vd_ff  <= v_dist_ff;
            rsp_hd_ff  <= h_dist_ff;
            rsp_col_ff <= h_wins ? h_col_ff : v_col_ff;
            rsp_row_ff <= h_wins ? h_row_ff : v_row_ff;
            rsp_x_ff   <= h_wins ? h_x_ff : v_x_ff;
            rsp_y_ff   <= h_wins ? h_y_ff : v_y_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_vertical_distance   = rsp_vd_ff;
   assign rsp_horizontal_distance = rsp_hd_ff;
   assign rsp_hit_col             = rsp_col_ff;
   assign rsp_hit_row             = rsp_row_ff;
   assign rsp_hit_x               = rsp_x_ff;
   assign rsp_hit_y               = rsp_y_ff;

endmodule
`default_nettype wire

>>> sv/grw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Grid ray wall intersect controller
// Sequences the map clear, tile writes and the two grid walks of a cast,
// issuing at most one datapath operation per cycle, none while it waits.
// ============================================================================
module grw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_cmd,
   output logic                    busy,
   output grw_pkg::grw_cmd_type    cmd,
   input  grw_pkg::grw_status_type status
);
   import grw_pkg::*;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_INIT     = 4'd2;
   localparam logic [3:0] S_DIV_HYP  = 4'd3;
   localparam logic [3:0] S_DIV_STEP = 4'd4;
   localparam logic [3:0] S_MUL_C_LO = 4'd5;
   localparam logic [3:0] S_MUL_C_HI = 4'd6;
   localparam logic [3:0] S_MUL_D_LO = 4'd7;
   localparam logic [3:0] S_MUL_D_HI = 4'd8;
   localparam logic [3:0] S_INDEX    = 4'd9;
   localparam logic [3:0] S_PROBE    = 4'd10;
   localparam logic [3:0] S_CHECK    = 4'd11;
   localparam logic [3:0] S_EMIT     = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       walk_ff, walk_in;

   always_comb begin
      state_in     = state_ff;
      walk_in      = walk_ff;
      cmd.op       = OP_NONE;
      cmd.walk_h   = walk_ff;
      cmd.mul_step = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               if (req_cmd) begin
                  cmd.op   = OP_LOAD;
                  walk_in  = 1'b0;
                  state_in = S_INIT;
               end else begin
                  cmd.op = OP_TILE_WR;
               end
            end
         end
         S_INIT: begin
            if (status.den_zero) begin
               cmd.op = OP_SAT;
               if (walk_ff) state_in = S_EMIT;
               else walk_in = 1'b1;
            end else begin
               cmd.op   = OP_INIT;
               state_in = S_DIV_HYP;
            end
         end
         S_DIV_HYP: begin
            if (status.div_done) begin
               cmd.op   = OP_CAP_HYP;
               state_in = S_DIV_STEP;
            end
         end
         S_DIV_STEP: begin
            if (status.div_done) begin
               cmd.op   = OP_CAP_STEP;
               state_in = S_MUL_C_LO;
            end
         end
         S_MUL_C_LO: begin
            cmd.op   = OP_MUL_LO;
            state_in = S_MUL_C_HI;
         end
         S_MUL_C_HI: begin
            cmd.op   = OP_MUL_HI;
            state_in = S_MUL_D_LO;
         end
         S_MUL_D_LO: begin
            cmd.op       = OP_MUL_LO;
            cmd.mul_step = 1'b1;
            state_in     = S_MUL_D_HI;
         end
         S_MUL_D_HI: begin
            cmd.op       = OP_MUL_HI;
            cmd.mul_step = 1'b1;
            state_in     = S_INDEX;
         end
         S_INDEX: begin
            cmd.op   = OP_INDEX;
            state_in = S_PROBE;
         end
         S_PROBE: begin
            cmd.op   = OP_PROBE;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.walk_stop) begin
               cmd.op = OP_SAVE;
               if (walk_ff) begin
                  state_in = S_EMIT;
               end else begin
                  walk_in  = 1'b1;
                  state_in = S_INIT;
               end
            end else begin
               cmd.op   = OP_ADVANCE;
               state_in = S_INDEX;
            end
         end
         S_EMIT: begin
            cmd.op   = OP_EMIT;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         walk_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Grid ray wall intersect testbench
// Writes tile maps and casts rays under several register settings. A
// scoreboard predicts the distances, the hit tile and the hit point of every
// cast and compares them with each result the block reports.
// ============================================================================

typedef struct {
   logic signed [23:0] vdist;
   logic [22:0]        hdist;
   logic signed [15:0] col;
   logic signed [15:0] row;
   logic signed [23:0] x;
   logic signed [23:0] y;
} cast_result_type;

class grw_scoreboard;
   localparam longint SIDE = 24;

   byte unsigned    tiles [SIDE*SIDE];
   int unsigned     shift_cfg;
   longint          maxdist_cfg;
   int unsigned     maxsteps_cfg;
   cast_result_type pending[$];
   int              errors;

   function new();
      foreach (tiles[i]) tiles[i] = 0;
      shift_cfg    = 6;
      maxdist_cfg  = 1536;
      maxsteps_cfg = 25;
      errors       = 0;
   endfunction

   function void write_register(logic [1:0] idx, logic [15:0] data);
      case (idx)
         grw_pkg::CSR_BLOCK_SHIFT:  shift_cfg = 32'(data[3:0]);
         grw_pkg::CSR_MAX_DISTANCE: maxdist_cfg = 64'(data);
         grw_pkg::CSR_MAX_STEPS:    maxsteps_cfg = 32'(data[5:0]);
         default: ;
      endcase
   endfunction

   function bit is_wall(longint row, longint col);
      if (row < 0 || row >= SIDE || col < 0 || col >= SIDE) return 0;
      return tiles[row*SIDE + col] != 0;
   endfunction

   function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // One grid walk along axis a; c is the cross axis.
   function void grid_walk(longint pa, longint pc, longint den, bit fwd, longint cf,
                           bit use_abs, bit vert, output longint walk_dist,
                           output longint apos, output longint cpos,
                           output longint aidx, output longint cidx);
      int unsigned bq;
      longint blk, lim, a, da, hyp, h2, c, dc, mag;
      int unsigned steps;
      bit hit;
      bq = 8 + shift_cfg;
      blk = longint'(1) << bq;
      lim = maxdist_cfg * 256;
      steps = 0;
      if (den == 0) begin
         walk_dist = 8388607;
         apos = 0; cpos = 0; aidx = 0; cidx = 0;
         return;
      end
      a = (pa >>> bq) * blk;
      if (fwd) a += blk;
      da = fwd ? blk : -blk;
      hyp = (a - pa) * 16384 / den;
      c = pc + ((hyp * cf) >>> 14);
      h2 = da * 16384 / den;
      dc = (h2 * cf) >>> 14;
      aidx = (a >>> bq) - (fwd ? 0 : 1);
      cidx = c >>> bq;
      hit = vert ? is_wall(cidx, aidx) : is_wall(aidx, cidx);
      while (!hit && steps < maxsteps_cfg) begin
         mag = (use_abs && hyp < 0) ? -hyp : hyp;
         if (mag >= lim) break;
         hyp += h2;
         a += da;
         c += dc;
         aidx = (a >>> bq) - (fwd ? 0 : 1);
         cidx = c >>> bq;
         hit = vert ? is_wall(cidx, aidx) : is_wall(aidx, cidx);
         steps++;
      end
      walk_dist = (use_abs && hyp < 0) ? -hyp : hyp;
      apos = a;
      cpos = c;
   endfunction

   function void note_request(logic cmd, logic [4:0] trow, logic [4:0] tcol,
                              logic [7:0] tval, logic [18:0] px, logic [18:0] py,
                              logic signed [15:0] sn, logic signed [15:0] cs);
      longint vd, va, vc, vai, vci, hd, ha, hc, hai, hci;
      longint col, row, x, y, sv, cv;
      cast_result_type e;
      if (!cmd) begin
         if (trow < SIDE && tcol < SIDE) tiles[trow*SIDE + tcol] = tval;
         return;
      end
      sv = longint'(sn);
      cv = longint'(cs);
      grid_walk(64'(px), 64'(py), cv, cv > 0, -sv, 0, 1, vd, va, vc, vai, vci);
      grid_walk(64'(py), 64'(px), sv, sv < 0, -cv, 1, 0, hd, ha, hc, hai, hci);
      vd = clip(vd, -8388608, 8388607);
      hd = clip(hd, 0, 8388607);
      if (hd < vd) begin
         col = hci; row = hai; x = hc; y = ha;
      end else begin
         col = vai; row = vci; x = va; y = vc;
      end
      e.vdist = 24'(vd);
      e.hdist = 23'(hd);
      e.col   = 16'(clip(col, -32768, 32767));
      e.row   = 16'(clip(row, -32768, 32767));
      e.x     = 24'(clip(x, -8388608, 8388607));
      e.y     = 24'(clip(y, -8388608, 8388607));
      pending.push_back(e);
   endfunction

   function void check_result(cast_result_type got);
      cast_result_type e;
      if (pending.size() == 0) begin
         $error("result with no cast request outstanding");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (got.vdist !== e.vdist) begin
         $error("vertical_distance exp %0d got %0d", e.vdist, got.vdist); errors++;
      end
      if (got.hdist !== e.hdist) begin
         $error("horizontal_distance exp %0d got %0d", e.hdist, got.hdist); errors++;
      end
      if (got.col !== e.col) begin
         $error("hit_col exp %0d got %0d", e.col, got.col); errors++;
      end
      if (got.row !== e.row) begin
         $error("hit_row exp %0d got %0d", e.row, got.row); errors++;
      end
      if (got.x !== e.x) begin
         $error("hit_x exp %0d got %0d", e.x, got.x); errors++;
      end
      if (got.y !== e.y) begin
         $error("hit_y exp %0d got %0d", e.y, got.y); errors++;
      end
   endfunction
endclass

module tb_top;
   import grw_pkg::*;

   localparam logic CMD_TILE = 1'b0;
   localparam logic CMD_CAST = 1'b1;
   localparam longint CYCLE_LIMIT = 4000000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic req_cmd = CMD_TILE;
   logic [RC_IN_W-1:0] req_tile_row = 0;
   logic [RC_IN_W-1:0] req_tile_col = 0;
   logic [TILE_W-1:0] req_tile_value = 0;
   logic [POS_W-1:0] req_player_x = 0;
   logic [POS_W-1:0] req_player_y = 0;
   logic signed [TRIG_W-1:0] req_sine_of_angle = 0;
   logic signed [TRIG_W-1:0] req_cosine_of_angle = 0;
   logic rsp_valid;
   logic signed [DIST_W-1:0] rsp_vertical_distance;
   logic [HDIST_W-1:0] rsp_horizontal_distance;
   logic signed [IDX_OUT_W-1:0] rsp_hit_col;
   logic signed [IDX_OUT_W-1:0] rsp_hit_row;
   logic signed [DIST_W-1:0] rsp_hit_x;
   logic signed [DIST_W-1:0] rsp_hit_y;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BLOCK_SHIFT;
   logic [CSR_DATA_W-1:0] csr_wdata = 0;

   grw_scoreboard sb = new();
   longint cycles = 0;
   bit quiet_phase;

   always #2 clock = ~clock;

   grid_ray_wall_intersect u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_tile_row(req_tile_row), .req_tile_col(req_tile_col),
      .req_tile_value(req_tile_value), .req_player_x(req_player_x),
      .req_player_y(req_player_y), .req_sine_of_angle(req_sine_of_angle),
      .req_cosine_of_angle(req_cosine_of_angle), .rsp_valid(rsp_valid),
      .rsp_vertical_distance(rsp_vertical_distance),
      .rsp_horizontal_distance(rsp_horizontal_distance),
      .rsp_hit_col(rsp_hit_col), .rsp_hit_row(rsp_hit_row),
      .rsp_hit_x(rsp_hit_x), .rsp_hit_y(rsp_hit_y),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("grid_ray_wall_intersect verification failed");
         $finish;
      end
   end

   // Outputs are sampled mid-cycle, where they are stable.
   always @(negedge clock) begin
      cast_result_type got;
      if (!reset && rsp_valid) begin
         got.vdist = rsp_vertical_distance;
         got.hdist = rsp_horizontal_distance;
         got.col   = rsp_hit_col;
         got.row   = rsp_hit_row;
         got.x     = rsp_hit_x;
         got.y     = rsp_hit_y;
         sb.check_result(got);
      end
   end

   function int pick_gap();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Called at a rising edge; start stays high into the next request when
   // there is no gap.
   task automatic send_request(logic cmd, logic [4:0] trow, logic [4:0] tcol,
                               logic [7:0] tval, logic [18:0] px, logic [18:0] py,
                               logic signed [15:0] sn, logic signed [15:0] cs);
      int gap;
      start <= 1;
      req_cmd <= cmd;
      req_tile_row <= trow;
      req_tile_col <= tcol;
      req_tile_value <= tval;
      req_player_x <= px;
      req_player_y <= py;
      req_sine_of_angle <= sn;
      req_cosine_of_angle <= cs;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      sb.note_request(cmd, trow, tcol, tval, px, py, sn, cs);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_tile(int row, int col, int val);
      send_request(CMD_TILE, 5'(row), 5'(col), 8'(val), '0, '0, '0, '0);
   endtask

   task automatic cast_ray(int px, int py, int sn, int cs);
      send_request(CMD_CAST, '0, '0, '0, 19'(px), 19'(py), 16'(sn), 16'(cs));
   endtask

   task automatic wait_idle();
      start <= 0;
      @(negedge clock);
      while (busy || sb.pending.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write.
   task automatic write_csr(logic [1:0] idx, logic [15:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      sb.write_register(idx, data);
   endtask

   task automatic set_config(int bs, int md, int ms);
      wait_idle();
      write_csr(CSR_BLOCK_SHIFT, 16'(bs));
      write_csr(CSR_MAX_DISTANCE, 16'(md));
      write_csr(CSR_MAX_STEPS, 16'(ms));
      csr_valid <= 0;
   endtask

   task automatic random_trig(output int sn, output int cs);
      int r;
      r = $urandom_range(0, 9);
      sn = $urandom_range(0, 32768) - 16384;
      cs = $urandom_range(0, 32768) - 16384;
      if (r == 0) sn = 0;
      else if (r == 1) cs = 0;
      else if (r == 2) sn = $urandom_range(0, 1) ? 16384 : -16384;
      else if (r == 3) cs = $urandom_range(0, 6) - 3;
   endtask

   task automatic random_items(int count);
      int sn, cs, val;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 30) begin
            val = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255);
            write_tile($urandom_range(0, 31), $urandom_range(0, 31), val);
         end else begin
            random_trig(sn, cs);
            cast_ray($urandom_range(0, 393215), $urandom_range(0, 393215), sn, cs);
         end
      end
      quiet_phase = 0;
   endtask

   initial begin
      quiet_phase = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // A few walls, value extremes, and writes that fall outside the map.
      write_tile(5, 14, 255);
      write_tile(12, 20, 1);
      write_tile(18, 12, 7);
      write_tile(12, 3, 128);
      write_tile(31, 2, 9);
      write_tile(4, 24, 9);
      write_tile(18, 12, 0);
      // Axis-aligned, diagonal, degenerate and edge-of-range casts.
      cast_ray(196608, 196608, 0, 16384);
      cast_ray(196608, 196608, 0, -16384);
      cast_ray(196608, 196608, 16384, 0);
      cast_ray(196608, 196608, -16384, 0);
      cast_ray(196608, 196608, 11585, 11585);
      cast_ray(196608, 196608, -11585, -11585);
      cast_ray(100000, 300000, 0, 0);
      cast_ray(0, 0, -11585, 11585);
      cast_ray(393215, 393215, 11585, -11585);
      cast_ray(0, 393215, 16384, 1);
      cast_ray(393215, 0, -1, -16384);

      random_items(160);
      set_config(0, 0, 0);
      random_items(120);
      set_config(15, 65535, 63);
      random_items(120);
      set_config(8, 65535, 63);
      random_items(120);
      set_config(3, 200, 10);
      random_items(120);
      set_config(6, 1536, 25);
      random_items(160);

      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("grid_ray_wall_intersect verification clean");
      else
         $display("grid_ray_wall_intersect verification failed");
      $finish;
   end
endmodule
